FILE: src/w2da_pkg.sv
// ----------------------------------------------------------------------------
// w2da_pkg: shared types and constants
// Widths, BCD adjust constants and the converter-to-emitter result bundle
// for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package w2da_pkg;

  // Field and digit widths.
  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CHAR_W     = 6;
  localparam int IDX_W      = 4;

  // Each converter step shifts this many value bits into the digit row.
  localparam int BITS_PER_STEP = 4;
  localparam int NUM_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(NUM_STEPS);

  // Shift-and-add-3 constants and the ASCII code of '0'.
  localparam logic [DIGIT_W-1:0] ADJ_THRESH = 4'h5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'h3;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;

  typedef logic [DIGIT_W-1:0] bcd_digit_t;

  // A finished conversion offered from the converter to the emitter.
  typedef struct packed {
    logic                              valid;
    logic                              keep_zeros;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
  } conv_result_t;

endpackage

FILE: src/word_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// word_to_decimal_ascii_core: binary to decimal ASCII converter
// Converts a 32-bit unsigned value to decimal with a row of double dabble
// digit cells and sends its digits as ASCII characters, most significant
// first, with the final one marked.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_value[31:0], in_keep_zeros
//   out_     output     out_valid / out_ready  out_digit_char[5:0], out_last
//
// A value passes through the digit row in 8 steps (four bits per cycle over
// 32 bits), then its 1 to 10 characters leave at one per cycle while out_ready
// is high. The next value converts while the previous one is still being sent.
// Reset (rst_n low, synchronous) empties the converter and the output.
// Stalls on out_ready hold the output register and back up into in_ready.
// ----------------------------------------------------------------------------
module word_to_decimal_ascii_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [w2da_pkg::VALUE_W-1:0]        in_value,
  input  logic                                in_keep_zeros,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [w2da_pkg::CHAR_W-1:0]         out_digit_char,
  output logic                                out_last
);

  w2da_pkg::conv_result_t conv_result;
  logic                   result_load;

  // Double dabble digit row.
  w2da_conv u_conv (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_keep_zeros (in_keep_zeros),
    .result        (conv_result),
    .result_load   (result_load)
  );

  // Character emitter with output register.
  w2da_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .result         (conv_result),
    .result_load    (result_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

FILE: src/w2da_cell.sv
// ----------------------------------------------------------------------------
// w2da_cell: one BCD digit cell
// Holds one decimal digit and runs several shift-and-add-3 rounds per cycle,
// taking bits from the lower neighbor and passing its carries upward.
// ----------------------------------------------------------------------------
module w2da_cell (
  input  logic                                clk,
  input  logic                                clear,
  input  logic                                shift_en,
  input  logic [w2da_pkg::BITS_PER_STEP-1:0]  shift_in,
  output logic [w2da_pkg::BITS_PER_STEP-1:0]  shift_out,
  output w2da_pkg::bcd_digit_t                digit
);

  w2da_pkg::bcd_digit_t digit_r;
  w2da_pkg::bcd_digit_t digit_nxt;

  // Rounds, all combinational: adjust, hand the top bit up, shift the next bit in.
  // The highest bit of shift_in and shift_out belongs to the first round.
  always_comb begin
    w2da_pkg::bcd_digit_t d;
    d         = digit_r;
    shift_out = '0;
    for (int j = 0; j < w2da_pkg::BITS_PER_STEP; j++) begin
      if (d >= w2da_pkg::ADJ_THRESH) begin
        d = d + w2da_pkg::ADJ_ADD;
      end
      shift_out[w2da_pkg::BITS_PER_STEP-1-j] = d[w2da_pkg::DIGIT_W-1];
      d = {d[w2da_pkg::DIGIT_W-2:0], shift_in[w2da_pkg::BITS_PER_STEP-1-j]};
    end
    digit_nxt = d;
  end

  // Digit register; a clear starts a new conversion from zero.
  always_ff @(posedge clk) begin
    if (clear) begin
      digit_r <= '0;
    end else if (shift_en) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

FILE: src/w2da_conv.sv
// ----------------------------------------------------------------------------
// w2da_conv: double dabble converter
// Feeds the input value, four bits per cycle, into a row of ten digit
// cells and offers the finished BCD digits to the emitter.
// ----------------------------------------------------------------------------
module w2da_conv (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [w2da_pkg::VALUE_W-1:0]        in_value,
  input  logic                                in_keep_zeros,
  output w2da_pkg::conv_result_t              result,
  input  logic                                result_load
);

  logic                                              busy_r;
  logic                                              done_r;
  logic [w2da_pkg::STEP_CNT_W-1:0]                   step_r;
  logic [w2da_pkg::VALUE_W-1:0]                      bin_r;
  logic                                              keep_r;
  logic                                              accept;
  logic [w2da_pkg::NUM_DIGITS-1:0][w2da_pkg::BITS_PER_STEP-1:0] carry;
  logic [w2da_pkg::NUM_DIGITS-1:0][w2da_pkg::DIGIT_W-1:0]       digits;

  // A new value enters once the row is free or its result leaves this cycle.
  assign in_ready = !busy_r && (!done_r || result_load);
  assign accept   = in_valid && in_ready;

  // Lowest cell takes the next value bits, most significant first.
  assign carry[0] = bin_r[w2da_pkg::VALUE_W-1 -: w2da_pkg::BITS_PER_STEP];

  // Row of digit cells, each feeding its carries to the next one up.
  for (genvar k = 0; k < w2da_pkg::NUM_DIGITS; k++) begin : g_cell
    if (k < w2da_pkg::NUM_DIGITS - 1) begin : g_mid
      w2da_cell u_cell (
        .clk       (clk),
        .clear     (accept),
        .shift_en  (busy_r),
        .shift_in  (carry[k]),
        .shift_out (carry[k+1]),
        .digit     (digits[k])
      );
    end else begin : g_top
      // The top digit of a 32-bit value never reaches five, so it has no carry.
      w2da_cell u_cell (
        .clk       (clk),
        .clear     (accept),
        .shift_en  (busy_r),
        .shift_in  (carry[k]),
        .shift_out (),
        .digit     (digits[k])
      );
    end
  end

  // Step sequencing and the finished flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == w2da_pkg::STEP_CNT_W'(w2da_pkg::NUM_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (result_load) begin
      done_r <= 1'b0;
    end
  end

  // Value shifter and the keep-zeros flag that travels with it.
  always_ff @(posedge clk) begin
    if (accept) begin
      bin_r  <= in_value;
      keep_r <= in_keep_zeros;
    end else if (busy_r) begin
      bin_r  <= {bin_r[w2da_pkg::VALUE_W-w2da_pkg::BITS_PER_STEP-1:0],
                 {w2da_pkg::BITS_PER_STEP{1'b0}}};
    end
  end

  assign result.valid      = done_r;
  assign result.keep_zeros = keep_r;
  assign result.digits     = digits;

endmodule

FILE: src/w2da_emit.sv
// ----------------------------------------------------------------------------
// w2da_emit: digit emitter
// Takes a finished set of BCD digits, skips leading zeros when asked and
// sends one ASCII character per transfer through an output register.
// ----------------------------------------------------------------------------
module w2da_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  w2da_pkg::conv_result_t              result,
  output logic                                result_load,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [w2da_pkg::CHAR_W-1:0]         out_digit_char,
  output logic                                out_last
);

  w2da_pkg::bcd_digit_t                dig_r [w2da_pkg::NUM_DIGITS];
  logic [w2da_pkg::IDX_W-1:0]          idx_r;
  logic                                active_r;
  logic                                out_valid_r;
  logic [w2da_pkg::CHAR_W-1:0]         out_char_r;
  logic                                out_last_r;
  logic                                move;
  logic                                final_move;
  logic [w2da_pkg::IDX_W-1:0]          start_idx;

  // A digit moves to the output register when that register is free.
  assign move        = active_r && (!out_valid_r || out_ready);
  assign final_move  = move && (idx_r == '0);
  assign result_load = result.valid && (!active_r || final_move);

  // First digit: top one if keep_zeros, else highest nonzero, else digit zero.
  always_comb begin
    start_idx = '0;
    for (int k = 0; k < w2da_pkg::NUM_DIGITS; k++) begin
      if (result.digits[k] != '0) begin
        start_idx = w2da_pkg::IDX_W'(k);
      end
    end
    if (result.keep_zeros) begin
      start_idx = w2da_pkg::IDX_W'(w2da_pkg::NUM_DIGITS - 1);
    end
  end

  // Digit store, loaded once per conversion.
  always_ff @(posedge clk) begin
    if (result_load) begin
      for (int k = 0; k < w2da_pkg::NUM_DIGITS; k++) begin
        dig_r[k] <= result.digits[k];
      end
    end
  end

  // Digit pointer counting down to the least significant digit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else if (result_load) begin
      active_r <= 1'b1;
      idx_r    <= start_idx;
    end else if (move) begin
      if (final_move) begin
        active_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (move) begin
      out_char_r <= w2da_pkg::ASCII_ZERO + {2'b00, dig_r[idx_r]};
      out_last_r <= (idx_r == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

endmodule

FILE: dv/word_to_decimal_ascii_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// word_to_decimal_ascii_checker: digit stream scoreboard
// Watches both channels of the converter. Every value taken in is turned
// into its expected ASCII digit string here. Every character sent out is
// compared with the oldest character still owed, one field at a time.
// ----------------------------------------------------------------------------
module word_to_decimal_ascii_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [w2da_pkg::VALUE_W-1:0]   in_value,
  input  logic                           in_keep_zeros,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [w2da_pkg::CHAR_W-1:0]    out_digit_char,
  input  logic                           out_last,
  output int                             mismatch_count,
  output int                             values_taken,
  output int                             chars_checked,
  output int                             chars_pending
);

  typedef struct packed {
    logic [w2da_pkg::CHAR_W-1:0] digit_char;
    logic                        last;
  } ascii_char_t;

  // Characters still owed by the block, oldest first.
  ascii_char_t owed_chars[$];

  initial begin
    mismatch_count = 0;
    values_taken   = 0;
    chars_checked  = 0;
    chars_pending  = 0;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Shift-and-add-3 conversion, then the digit string with leading zeros
  // dropped unless they are to be kept.
  function automatic void queue_decimal_chars(
      input logic [w2da_pkg::VALUE_W-1:0] value,
      input logic keep);
    logic [w2da_pkg::NUM_DIGITS*w2da_pkg::DIGIT_W-1:0] bcd;
    logic [w2da_pkg::VALUE_W-1:0]                      bin;
    w2da_pkg::bcd_digit_t                              d;
    logic                                              leading;
    ascii_char_t                                       row[$];
    ascii_char_t                                       c;
    bcd   = '0;
    bin   = value;
    for (int r = 0; r < w2da_pkg::VALUE_W; r++) begin
      for (int k = 0; k < w2da_pkg::NUM_DIGITS; k++) begin
        if (bcd[w2da_pkg::DIGIT_W*k +: w2da_pkg::DIGIT_W] >= w2da_pkg::ADJ_THRESH)
          bcd[w2da_pkg::DIGIT_W*k +: w2da_pkg::DIGIT_W] =
              bcd[w2da_pkg::DIGIT_W*k +: w2da_pkg::DIGIT_W] + w2da_pkg::ADJ_ADD;
      end
      bcd = {bcd[w2da_pkg::NUM_DIGITS*w2da_pkg::DIGIT_W-2:0], bin[w2da_pkg::VALUE_W-1]};
      bin = bin << 1;
    end

    // A zero with zeros suppressed still gives one '0'.
    if (value == '0 && !keep) begin
      c.digit_char = w2da_pkg::ASCII_ZERO;
      c.last       = 1'b0;
      row.push_back(c);
    end else begin
      leading = !keep;
      for (int k = w2da_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
        d = bcd[w2da_pkg::DIGIT_W*k +: w2da_pkg::DIGIT_W];
        if (d != '0) leading = 1'b0;
        if (!leading) begin
          c.digit_char = w2da_pkg::ASCII_ZERO + w2da_pkg::CHAR_W'(d);
          c.last       = 1'b0;
          row.push_back(c);
        end
      end
    end
    row[row.size()-1].last = 1'b1;
    foreach (row[i]) owed_chars.push_back(row[i]);
  endfunction

  // Input transfers add owed characters; output transfers are checked.
  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        queue_decimal_chars(in_value, in_keep_zeros);
        values_taken++;
      end
      if (out_valid && out_ready) begin
        chars_checked++;
        if (owed_chars.size() == 0) begin
          report_mismatch($sformatf("character %0d (last %0b) sent with none owed",
                                    out_digit_char, out_last));
        end else begin
          want = owed_chars.pop_front();
          if (out_digit_char !== want.digit_char)
            report_mismatch($sformatf("digit_char %0d, wanted %0d",
                                      out_digit_char, want.digit_char));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b, wanted %0b on digit_char %0d",
                                      out_last, want.last, want.digit_char));
        end
      end
      chars_pending = owed_chars.size();
    end
  end

endmodule

FILE: dv/tb_word_to_decimal_ascii_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_word_to_decimal_ascii_core: converter testbench top
// Drives edge values and a random sweep of 32-bit numbers with and without
// leading zeros into the converter, throttles both channels at random and
// twice blocks the output long enough to back up the input. The checker
// beside the block predicts every character and counts mismatches.
// ----------------------------------------------------------------------------
module tb_word_to_decimal_ascii_core;

  localparam int RANDOM_VALUES   = 350;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int IDLE_PERCENT    = 13;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [w2da_pkg::VALUE_W-1:0]  in_value;
  logic                          in_keep_zeros;
  logic                          out_valid;
  logic                          out_ready;
  logic [w2da_pkg::CHAR_W-1:0]   out_digit_char;
  logic                          out_last;

  int   mismatch_count;
  int   values_taken;
  int   chars_checked;
  int   chars_pending;
  logic in_took = 1'b0;
  logic quiet_phase = 1'b0;
  logic hold_off_req = 1'b0;
  int   stalled_cycles = 0;

  always #6 clk = ~clk;

  word_to_decimal_ascii_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_keep_zeros  (in_keep_zeros),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  word_to_decimal_ascii_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_keep_zeros  (in_keep_zeros),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .values_taken   (values_taken),
    .chars_checked  (chars_checked),
    .chars_pending  (chars_pending)
  );

  // Input transfer flag, read by the sender at the following falling edge.
  always @(posedge clk) in_took <= rst_n && in_valid && in_ready;

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Offers one value, after an occasional gap, and waits for its transfer.
  task automatic send_value(input logic [w2da_pkg::VALUE_W-1:0] value, input logic keep);
    int gap;
    if (!quiet_phase && $urandom_range(99) < IDLE_PERCENT) begin
      gap      = $urandom_range(4, 1);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_value      = value;
    in_keep_zeros = keep;
    do @(negedge clk); while (!in_took);
  endtask

  // Random values: full range, small numbers, powers of ten and their
  // neighbors, the two extremes, and numbers of random bit length.
  function automatic logic [w2da_pkg::VALUE_W-1:0] pick_value();
    int unsigned                  kind;
    logic [w2da_pkg::VALUE_W-1:0] p;
    kind = $urandom_range(9);
    p    = 1;
    case (kind)
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(999);
      6, 7: begin
        repeat ($urandom_range(w2da_pkg::NUM_DIGITS - 1)) p = p * 10;
        return p + $urandom_range(2) - 1;
      end
      8:          return $urandom_range(1) ? '1 : '0;
      default:    return $urandom >> $urandom_range(w2da_pkg::VALUE_W - 1);
    endcase
  endfunction

  // Receiver: random stalls, a quiet stretch, and long hold-offs on request.
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready = quiet_phase || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Reset, directed edge values, random sweep, drain and verdict.
  initial begin : stimulus
    logic [w2da_pkg::VALUE_W-1:0] edge_values[$];
    in_valid      = 1'b0;
    in_value      = '0;
    in_keep_zeros = 1'b0;
    rst_n         = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Extremes, digit-count boundaries and single set bits.
    edge_values = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
                    32'd999_999_999, 32'd1_000_000_000, 32'd4_294_967_290,
                    32'h8000_0000, 32'h7FFF_FFFF};
    foreach (edge_values[i]) begin
      send_value(edge_values[i], 1'b0);
      send_value(edge_values[i], 1'b1);
    end

    // Random sweep, with two long output hold-offs and one quiet stretch.
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      if (n == 40 || n == 280) hold_off_req = 1'b1;
      quiet_phase = (n >= 150 && n < 220);
      send_value(pick_value(), $urandom_range(1));
    end
    in_valid    = 1'b0;
    quiet_phase = 1'b0;

    // Drain, then give the block time to show any stray character.
    while (chars_pending != 0 || hold_off_req) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d values in, %0d digit characters out, edge values first,",
             values_taken, chars_checked);
    $display("then random values with gaps, stalls and a blocked output.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
